FILE: rtl/core/svp_pkg.sv
// shared constants, codes and types for the stack with value purge
package svp_pkg;

    // store geometry
    localparam int DEPTH   = 64;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;
    localparam int COUNT_MAX = 127;

    // stream packing
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_PURGE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND  = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd3;

    // movement of the cell row
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_DOWN = 2'd1,
        SH_UP   = 2'd2
    } t_shift;

    // control group from the sequencer to the cell row
    typedef struct packed {
        t_shift           mode;
        logic             inject;
        logic [IDX_W-1:0] tail;
    } t_chain_ctl;

endpackage

FILE: rtl/core/stack_with_value_purge_top.sv
// top level of the stack with value purge: sequencer, occupancy and result register
// push and pop: result registered into the output register in the cycle after the item is accepted,
//   and a new item can be taken every cycle while the result register drains
// purge: one cell of the row examined per cycle, then the result waits for a free result register; input is held off
// reset (i_rst_n low, synchronous) empties the stack and drops any pending result;
//   cell contents are not cleared, entries above the occupancy are never read
module stack_with_value_purge_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input item: [1:0] op, [33:2] value, [39:34] zero
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [svp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // result item: [31:0] popped_value, [33:32] status, [40:34] removed_count, [47:41] zero
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [svp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import svp_pkg::*;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_PURGE = 2'b10
    } t_state;

    t_state r_state, n_state;

    // field unpacking
    logic [OP_W-1:0]   w_op;
    logic [DATA_W-1:0] w_value;
    assign w_op    = s_axis_tdata[OP_W-1:0];
    assign w_value = s_axis_tdata[OP_W +: DATA_W];

    // occupancy of the row
    logic [CNT_W-1:0] r_occ, n_occ;

    // purge pass: entries left to examine, running length, removed count, key
    logic [CNT_W-1:0]  r_left, n_left;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [DATA_W-1:0] r_key, n_key;

    // result register
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_out_popped, n_out_popped;
    logic [STAT_W-1:0]  r_out_status, n_out_status;
    logic [COUNT_W-1:0] r_out_count, n_out_count;

    // cell row
    t_chain_ctl        w_ctl;
    logic [DATA_W-1:0] w_bus;
    logic [DATA_W-1:0] w_top;

    logic w_out_free;
    logic w_accept;
    logic w_match;
    logic [31:0] w_rem_ext;

    // result register can take a new item when empty or being drained
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_match       = (w_top == r_key);

    // removed count saturates to the field width
    assign w_rem_ext = 32'(r_rem);

    svp_chain u_chain (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_bus (w_bus),
        .o_top (w_top)
    );

    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_left       = r_left;
        n_len        = r_len;
        n_rem        = r_rem;
        n_key        = r_key;
        n_out_popped = r_out_popped;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_valid  = r_out_valid && !m_axis_tready;

        w_ctl.mode   = SH_HOLD;
        w_ctl.inject = 1'b0;
        w_ctl.tail   = '0;
        w_bus        = w_value;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_popped = '0;
                    n_out_status = ST_OK;
                    n_out_count  = '0;
                    n_out_valid  = 1'b1;
                    unique case (w_op)
                        OP_PUSH: begin
                            if (r_occ < CNT_W'(DEPTH)) begin
                                // everything moves one cell deeper, new item enters cell 0
                                w_ctl.mode   = SH_DOWN;
                                w_ctl.inject = 1'b1;
                                w_ctl.tail   = '0;
                                n_occ        = r_occ + CNT_W'(1);
                            end else begin
                                n_out_status = ST_OVERFLOW;
                            end
                        end
                        OP_POP: begin
                            if (r_occ == '0) begin
                                n_out_popped = '1;
                                n_out_status = ST_UNDERFLOW;
                            end else begin
                                w_ctl.mode   = SH_UP;
                                n_out_popped = w_top;
                                n_occ        = r_occ - CNT_W'(1);
                            end
                        end
                        OP_PURGE: begin
                            // result comes at the end of the pass
                            n_out_valid = 1'b0;
                            n_key       = w_value;
                            n_left      = r_occ;
                            n_len       = r_occ;
                            n_rem       = '0;
                            n_state     = S_PURGE;
                        end
                        default: begin
                            // unused code: no change, all-zero result
                        end
                    endcase
                end
            end
            S_PURGE: begin
                if (r_left != '0) begin
                    // rotate: top leaves, kept items re-enter behind the survivors
                    w_ctl.mode = SH_UP;
                    w_bus      = w_top;
                    n_left     = r_left - CNT_W'(1);
                    if (w_match) begin
                        n_len = r_len - CNT_W'(1);
                        n_rem = r_rem + CNT_W'(1);
                    end else begin
                        w_ctl.inject = 1'b1;
                        w_ctl.tail   = IDX_W'(r_len - CNT_W'(1));
                    end
                end else if (w_out_free) begin
                    n_occ        = r_len;
                    n_out_valid  = 1'b1;
                    n_out_popped = '0;
                    n_out_status = (r_rem == '0) ? ST_NOTFOUND : ST_OK;
                    n_out_count  = (w_rem_ext > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                                : w_rem_ext[COUNT_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and pass bookkeeping, no reset needed
    always_ff @(posedge i_clk) begin
        r_left       <= n_left;
        r_len        <= n_len;
        r_rem        <= n_rem;
        r_key        <= n_key;
        r_out_popped <= n_out_popped;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - COUNT_W - STAT_W - DATA_W)'(0),
                            r_out_count, r_out_status, r_out_popped};

endmodule

FILE: rtl/core/svp_cell.sv
// one storage cell of the stack row
module svp_cell (
    input  logic                        i_clk,
    input  svp_pkg::t_shift             i_mode,
    input  logic                        i_inject,
    input  logic [svp_pkg::DATA_W-1:0]  i_bus,
    input  logic [svp_pkg::DATA_W-1:0]  i_prev,
    input  logic [svp_pkg::DATA_W-1:0]  i_next,
    output logic [svp_pkg::DATA_W-1:0]  o_q
);
    import svp_pkg::*;

    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_inject) begin
            n_q = i_bus;
        end else begin
            case (i_mode)
                SH_DOWN: n_q = i_prev;
                SH_UP:   n_q = i_next;
                default: n_q = r_q;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

FILE: rtl/core/svp_chain.sv
// row of storage cells, cell 0 holds the top of the stack
module svp_chain (
    input  logic                        i_clk,
    input  svp_pkg::t_chain_ctl         i_ctl,
    input  logic [svp_pkg::DATA_W-1:0]  i_bus,
    output logic [svp_pkg::DATA_W-1:0]  o_top
);
    import svp_pkg::*;

    logic [DATA_W-1:0] w_q [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_prev;
        logic [DATA_W-1:0] w_next;
        logic              w_inject;

        if (g == 0) begin : g_first
            assign w_prev = i_bus;
        end else begin : g_mid_prev
            assign w_prev = w_q[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_next
            assign w_next = w_q[g+1];
        end

        assign w_inject = i_ctl.inject && (i_ctl.tail == IDX_W'(g));

        svp_cell u_cell (
            .i_clk    (i_clk),
            .i_mode   (i_ctl.mode),
            .i_inject (w_inject),
            .i_bus    (i_bus),
            .i_prev   (w_prev),
            .i_next   (w_next),
            .o_q      (w_q[g])
        );
    end

    assign o_top = w_q[0];

endmodule

FILE: rtl/core/svp_checker.sv
// port-level checks on the stack with value purge, bound to the top level
module svp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [svp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [svp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import svp_pkg::*;

    logic [DATA_W-1:0]  w_popped;
    logic [STAT_W-1:0]  w_status;
    logic [COUNT_W-1:0] w_count;

    assign w_popped = m_axis_tdata[DATA_W-1:0];
    assign w_status = m_axis_tdata[DATA_W +: STAT_W];
    assign w_count  = m_axis_tdata[DATA_W + STAT_W +: COUNT_W];

    // stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // no result pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result item present after reset");

    // underflow always reports minus one
    a_underflow_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == ST_UNDERFLOW) |-> (w_popped == '1) && (w_count == '0))
        else $error("underflow without minus one");

    // a nonzero removed count only comes with an ok status and no popped value
    a_count_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_count != '0) |-> (w_status == ST_OK) && (w_popped == '0))
        else $error("removed count with wrong status");

    // input is never taken while a stalled result would be overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken over a stalled result");

endmodule

bind stack_with_value_purge_top svp_checker u_svp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
